>>> design/dtd_pkg.sv
// shared types, widths and calendar helpers for the date-time difference block
package dtd_pkg;

  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;

  localparam int unsigned DateW   = YearW + MonthW + DayW + HourW + MinuteW + SecondW;
  localparam int unsigned InDataW = 80;
  localparam int unsigned OutDataW = 40;

  localparam logic [SecondW-1:0] SecondBase = SecondW'(60);
  localparam logic [MinuteW-1:0] MinuteBase = MinuteW'(60);
  localparam logic [HourW-1:0]   HourBase   = HourW'(24);
  localparam logic [MonthW-1:0]  MonthBase  = MonthW'(12);

  localparam logic [MonthW-1:0]  MonthFeb   = MonthW'(2);
  localparam logic [DayW-1:0]    FebLeapLen = DayW'(29);

  // inverse of 25 modulo 2**12 and the largest multiple-of-25 quotient in 12 bits
  localparam logic [YearW-1:0]   Inv25      = YearW'(3113);
  localparam logic [YearW-1:0]   Max25Quot  = YearW'(163);

  // first member sits in the highest bits, so year lands at bit 0
  typedef struct packed {
    logic [SecondW-1:0] second;
    logic [MinuteW-1:0] minute;
    logic [HourW-1:0]   hour;
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
  } date_t;

  typedef struct packed {
    logic [SecondW-1:0] seconds;
    logic [MinuteW-1:0] minutes;
    logic [HourW-1:0]   hours;
    logic [DayW-1:0]    days;
    logic [MonthW-1:0]  months;
    logic [YearW-1:0]   years;
  } diff_t;

  // days in a month by 4-bit code, codes outside 1..12 count as 31
  function automatic logic [DayW-1:0] base_month_len(input logic [MonthW-1:0] month);
    logic [DayW-1:0] len;
    unique case (month) inside
      4'd2:                    len = DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11: len = DayW'(30);
      default:                 len = DayW'(31);
    endcase
    return len;
  endfunction

  // gregorian leap rule, division by 25 tested through the modular inverse
  function automatic logic is_leap(input logic [YearW-1:0] year);
    logic [YearW-1:0] prod;
    logic             div25;
    logic             div100;
    logic             div400;
    // only the product modulo 2**12 matters
    prod   = year * Inv25;
    div25  = (prod <= Max25Quot);
    div100 = (year[1:0] == 2'b00) && div25;
    div400 = (year[3:0] == 4'b0000) && div25;
    return (year[1:0] == 2'b00) && (!div100 || div400);
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [YearW-1:0]  year,
                                                input logic [MonthW-1:0] month);
    logic [DayW-1:0] len;
    len = base_month_len(month);
    if (month == MonthFeb && is_leap(year)) begin
      len = FebLeapLen;
    end
    return len;
  endfunction

endpackage

>>> design/dtd_order.sv
// orders two date-times into the later and the earlier one
module dtd_order (
  input  dtd_pkg::date_t first_i,
  input  dtd_pkg::date_t second_i,
  output dtd_pkg::date_t late_o,
  output dtd_pkg::date_t early_o
);

  logic [dtd_pkg::DateW-1:0] first_key;
  logic [dtd_pkg::DateW-1:0] second_key;
  logic                      first_earlier;

  // year in the top bits so one compare gives the field-by-field order
  assign first_key  = {first_i.year, first_i.month, first_i.day,
                       first_i.hour, first_i.minute, first_i.second};
  assign second_key = {second_i.year, second_i.month, second_i.day,
                       second_i.hour, second_i.minute, second_i.second};

  assign first_earlier = (first_key < second_key);

  assign late_o  = first_earlier ? second_i : first_i;
  assign early_o = first_earlier ? first_i  : second_i;

endmodule

>>> design/date_time_difference.sv
// top level: three-stage pipeline computing the calendar difference of two date-times
//
//  channel  dir  beat contents (tdata from bit 0 up)
//  s_axis   in   first_* date then second_* date, 76 bits padded to 80
//  m_axis   out  diff_years .. diff_seconds, 38 bits padded to 40
//
// one pair accepted per cycle unless a stall on m_axis holds the pipeline
// stage 1 registers the ordered pair, stage 2 the second/minute/hour borrow
// chain plus the earlier month length, stage 3 (output register) day/month/year
// reset clears only the stage valid bits, data registers are not reset
// a stall on m_axis backs up stage by stage; a stage takes a beat when empty
// or when the next one moves, so nothing is dropped or repeated
module date_time_difference (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // first_year, first_month, first_day, first_hour, first_minute, first_second,
  // second_year, second_month, second_day, second_hour, second_minute,
  // second_second, zero pad
  input  logic [dtd_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // diff_years, diff_months, diff_days, diff_hours, diff_minutes, diff_seconds,
  // zero pad
  output logic [dtd_pkg::OutDataW-1:0]  m_axis_tdata
);

  // ---------------------------------------------------------------- handshake
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic adv1, adv2, adv3;

  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign adv1 = s_axis_tvalid && rdy1;
  assign adv2 = v1_q && rdy2;
  assign adv3 = v2_q && rdy3;

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------- stage 1
  dtd_pkg::date_t first_in, second_in;
  dtd_pkg::date_t late_d, early_d;
  dtd_pkg::date_t late_q, early_q;

  assign first_in  = dtd_pkg::date_t'(s_axis_tdata[dtd_pkg::DateW-1:0]);
  assign second_in = dtd_pkg::date_t'(s_axis_tdata[2*dtd_pkg::DateW-1:dtd_pkg::DateW]);

  dtd_order u_order (
    .first_i  (first_in),
    .second_i (second_in),
    .late_o   (late_d),
    .early_o  (early_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      late_q  <= late_d;
      early_q <= early_d;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // subtract seconds, minutes and hours, each borrow feeding the next field
  logic                         brw_sec, brw_min, brw_hour;
  logic [dtd_pkg::SecondW-1:0]  dsec_d;
  logic [dtd_pkg::MinuteW-1:0]  dmin_d;
  logic [dtd_pkg::HourW-1:0]    dhour_d;
  logic [dtd_pkg::DayW-1:0]     mlen_d;

  always_comb begin
    brw_sec = (late_q.second < early_q.second);
    dsec_d  = late_q.second - early_q.second
              + (brw_sec ? dtd_pkg::SecondBase : dtd_pkg::SecondW'(0));

    brw_min = ({1'b0, late_q.minute} <
               ({1'b0, early_q.minute} + (dtd_pkg::MinuteW+1)'(brw_sec)));
    dmin_d  = late_q.minute - early_q.minute - dtd_pkg::MinuteW'(brw_sec)
              + (brw_min ? dtd_pkg::MinuteBase : dtd_pkg::MinuteW'(0));

    brw_hour = ({1'b0, late_q.hour} <
                ({1'b0, early_q.hour} + (dtd_pkg::HourW+1)'(brw_min)));
    dhour_d  = late_q.hour - early_q.hour - dtd_pkg::HourW'(brw_min)
               + (brw_hour ? dtd_pkg::HourBase : dtd_pkg::HourW'(0));

    // length of the earlier date's month, used if the day field borrows
    mlen_d = dtd_pkg::month_len(early_q.year, early_q.month);
  end

  logic [dtd_pkg::SecondW-1:0] dsec_q;
  logic [dtd_pkg::MinuteW-1:0] dmin_q;
  logic [dtd_pkg::HourW-1:0]   dhour_q;
  logic                        brw_hour_q;
  logic [dtd_pkg::DayW-1:0]    mlen_q;
  logic [dtd_pkg::YearW-1:0]   late_year_q, early_year_q;
  logic [dtd_pkg::MonthW-1:0]  late_month_q, early_month_q;
  logic [dtd_pkg::DayW-1:0]    late_day_q, early_day_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      dsec_q        <= dsec_d;
      dmin_q        <= dmin_d;
      dhour_q       <= dhour_d;
      brw_hour_q    <= brw_hour;
      mlen_q        <= mlen_d;
      late_year_q   <= late_q.year;
      early_year_q  <= early_q.year;
      late_month_q  <= late_q.month;
      early_month_q <= early_q.month;
      late_day_q    <= late_q.day;
      early_day_q   <= early_q.day;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // days borrow the length of the earlier date's month, months borrow a year
  logic            brw_day, brw_month;
  dtd_pkg::diff_t  diff_d, diff_q;

  always_comb begin
    brw_day = ({1'b0, late_day_q} <
               ({1'b0, early_day_q} + (dtd_pkg::DayW+1)'(brw_hour_q)));
    brw_month = ({1'b0, late_month_q} <
                 ({1'b0, early_month_q} + (dtd_pkg::MonthW+1)'(brw_day)));

    diff_d.seconds = dsec_q;
    diff_d.minutes = dmin_q;
    diff_d.hours   = dhour_q;
    diff_d.days    = late_day_q - early_day_q - dtd_pkg::DayW'(brw_hour_q)
                     + (brw_day ? mlen_q : dtd_pkg::DayW'(0));
    diff_d.months  = late_month_q - early_month_q - dtd_pkg::MonthW'(brw_day)
                     + (brw_month ? dtd_pkg::MonthBase : dtd_pkg::MonthW'(0));
    diff_d.years   = late_year_q - early_year_q - dtd_pkg::YearW'(brw_month);
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      diff_q <= diff_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {(dtd_pkg::OutDataW-dtd_pkg::DateW)'(0), diff_q};

  // ---------------------------------------------------------------- checks
  // stage 1 always holds the pair in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> ({late_q.year, late_q.month, late_q.day, late_q.hour,
               late_q.minute, late_q.second} >=
              {early_q.year, early_q.month, early_q.day, early_q.hour,
               early_q.minute, early_q.second}))
    else $error("stage 1 pair out of order");

  // a beat moving out of stage 1 arrives in stage 2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv2 |=> v2_q)
    else $error("stage 2 lost a beat");

  // a beat moving out of stage 2 arrives at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv3 |=> m_axis_tvalid)
    else $error("output stage lost a beat");

  // equal dates leave no time difference and no borrow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv2 && late_q == early_q) |=>
      (dsec_q == '0 && dmin_q == '0 && dhour_q == '0 && !brw_hour_q))
    else $error("equal dates gave a nonzero time difference");

endmodule
